// File: rtl/core/tpss_pkg.sv
// Shared types, codes and constants of the tiered position slew stepper.
`default_nettype none

package tpss_pkg;

  localparam int RADIUS_W   = 20;
  localparam int COUNT_W    = 12;
  localparam int NUM_TIERS  = 5;
  localparam int TIER_IDX_W = 3;
  localparam int STEP_W     = 4;
  localparam int CFG_IDX_W  = 3;

  typedef logic [RADIUS_W-1:0] radius_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [STEP_W-1:0]   step_t;

  typedef struct packed {
    radius_t [NUM_TIERS-1:0] tier;
    radius_t                 arrive;
  } radii_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_COLLIDE = 2'd1,
    KIND_FREE    = 2'd2,
    KIND_SNAP    = 2'd3
  } write_kind_t;

  localparam logic OP_SET_TARGET = 1'b0;
  localparam logic OP_TICK       = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TIER1   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIER2   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIER3   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIER4   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIER5   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd6;

  localparam radius_t RST_TIER1   = 20'd140;
  localparam radius_t RST_TIER2   = 20'd200;
  localparam radius_t RST_TIER3   = 20'd400;
  localparam radius_t RST_TIER4   = 20'd600;
  localparam radius_t RST_TIER5   = 20'd800;
  localparam radius_t RST_ARRIVE  = 20'd100;
  localparam count_t  RST_TIMEOUT = 12'd3000;

  localparam count_t COUNT_MAX = 12'hFFF;

  // The first two tiers are collision-aware moves, the rest are free moves.
  localparam logic [TIER_IDX_W-1:0] FIRST_FREE_TIER = 3'd2;

  // Step size of each tier in half units.
  function automatic step_t tier_step(input logic [TIER_IDX_W-1:0] idx);
    step_t s;
    unique case (idx)
      3'd0:    s = 4'd1;
      3'd1:    s = 4'd2;
      3'd2:    s = 4'd4;
      3'd3:    s = 4'd6;
      3'd4:    s = 4'd8;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tiered_position_slew_stepper_unit.sv
// Top level of the tiered position slew stepper: registers, control and state.
//
// Usage: an item on the in_ channel is either a set-target (stores the goal and
// arms the block) or a tick carrying the current position. Every item yields
// exactly one result item on the out_ channel with the written position, the
// kind of write and whether the block is still armed afterwards.
// An item is taken at an edge where its valid is high and stall is low.
// A taken item waits in the input register and moves on into the result register,
// raising out_valid, when that register is empty or out_stall is low. One input
// register, then the tier choice, per-axis step and timeout logic feed the result
// register. Throughput is one item per cycle while out_stall is low; the goal,
// armed flag and tick counter are updated at the same edge as the result register,
// so the next item sees them. When out_stall holds a result, the item behind it
// waits in the input register and in_stall rises only once both are full.
// Configuration writes on cfg_ are always ready and should be done while idle.
// Synchronous active-low reset clears the armed flag, counter, goal and valid
// flags, and loads the radii and timeout limit with their defaults.
`default_nettype none

module tiered_position_slew_stepper_unit
  import tpss_pkg::*;
#(
  parameter int COORD_BITS = 26
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_operation,
  input  wire logic signed [COORD_BITS-1:0] in_target_x,
  input  wire logic signed [COORD_BITS-1:0] in_target_y,
  input  wire logic signed [COORD_BITS-1:0] in_target_z,
  input  wire logic signed [COORD_BITS-1:0] in_now_x,
  input  wire logic signed [COORD_BITS-1:0] in_now_y,
  input  wire logic signed [COORD_BITS-1:0] in_now_z,

  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COORD_BITS-1:0]      out_pos_x,
  output logic signed [COORD_BITS-1:0]      out_pos_y,
  output logic signed [COORD_BITS-1:0]      out_pos_z,
  output logic [1:0]                        out_write_kind,
  output logic                              out_active_after,

  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [RADIUS_W-1:0]          cfg_data
);

  // Configuration.
  radii_t radii_r;
  count_t timeout_r;

  // Input register.
  logic                         in_vld_r;
  logic                         op_r;
  logic signed [COORD_BITS-1:0] tgt_r [3];
  logic signed [COORD_BITS-1:0] now_r [3];

  // Block state.
  logic                         active_r, active_nxt;
  logic signed [COORD_BITS-1:0] goal_r [3];
  count_t                       count_r, count_nxt;

  // Result register.
  logic                         out_vld_r;
  logic signed [COORD_BITS-1:0] pos_r [3];
  logic signed [COORD_BITS-1:0] pos_nxt [3];
  write_kind_t                  kind_r, kind_nxt;
  logic                         act_out_r;

  logic                         advance;
  logic                         in_accept;

  logic [NUM_TIERS-1:0]         hit_ax [3];
  logic [NUM_TIERS-1:0]         tier_hit;
  logic signed [COORD_BITS-1:0] moved [3];
  logic [2:0]                   arrive_ax;
  logic                         any_tier;
  logic [TIER_IDX_W-1:0]        tier_idx;
  step_t                        step;
  count_t                       count_base;
  count_t                       count_inc;

  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radii_r.tier[0] <= RST_TIER1;
      radii_r.tier[1] <= RST_TIER2;
      radii_r.tier[2] <= RST_TIER3;
      radii_r.tier[3] <= RST_TIER4;
      radii_r.tier[4] <= RST_TIER5;
      radii_r.arrive  <= RST_ARRIVE;
      timeout_r       <= RST_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIER1:   radii_r.tier[0] <= cfg_data;
        CFG_TIER2:   radii_r.tier[1] <= cfg_data;
        CFG_TIER3:   radii_r.tier[2] <= cfg_data;
        CFG_TIER4:   radii_r.tier[3] <= cfg_data;
        CFG_TIER5:   radii_r.tier[4] <= cfg_data;
        CFG_ARRIVE:  radii_r.arrive  <= cfg_data;
        CFG_TIMEOUT: timeout_r       <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_accept) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r     <= in_operation;
      tgt_r[0] <= in_target_x;
      tgt_r[1] <= in_target_y;
      tgt_r[2] <= in_target_z;
      now_r[0] <= in_now_x;
      now_r[1] <= in_now_y;
      now_r[2] <= in_now_z;
    end
  end

  // Tier choice is shared by all axes, so the step is picked before the move.
  always_comb begin
    tier_hit = hit_ax[0] & hit_ax[1] & hit_ax[2];
    any_tier = |tier_hit;
    tier_idx = '0;
    for (int t = NUM_TIERS - 1; t >= 0; t--) begin
      if (tier_hit[t]) begin
        tier_idx = TIER_IDX_W'(t);
      end
    end
    step = tier_step(tier_idx);
  end

  genvar a;
  generate
    for (a = 0; a < 3; a++) begin : g_axis
      tpss_axis #(
        .COORD_BITS (COORD_BITS)
      ) u_axis (
        .now        (now_r[a]),
        .goal       (goal_r[a]),
        .radii      (radii_r),
        .step       (step),
        .tier_hit   (hit_ax[a]),
        .moved      (moved[a]),
        .arrive_hit (arrive_ax[a])
      );
    end
  endgenerate

  always_comb begin
    active_nxt = active_r;
    count_nxt  = count_r;
    kind_nxt   = KIND_NONE;
    count_base = count_r;
    count_inc  = count_r;
    for (int i = 0; i < 3; i++) begin
      pos_nxt[i] = '0;
    end
    if (op_r == OP_SET_TARGET) begin
      active_nxt = 1'b1;
    end else if (active_r && any_tier) begin
      kind_nxt = (tier_idx < FIRST_FREE_TIER) ? KIND_COLLIDE : KIND_FREE;
      for (int i = 0; i < 3; i++) begin
        pos_nxt[i] = moved[i];
      end
      // Arrival clears the counter first; the tick is still counted after.
      if (&arrive_ax) begin
        active_nxt = 1'b0;
        count_base = '0;
      end
      count_inc = (count_base != COUNT_MAX) ? count_base + 1'b1 : count_base;
      count_nxt = count_inc;
      if (count_inc > timeout_r) begin
        for (int i = 0; i < 3; i++) begin
          pos_nxt[i] = goal_r[i];
        end
        kind_nxt   = KIND_SNAP;
        count_nxt  = '0;
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      count_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        goal_r[i] <= '0;
      end
    end else if (advance) begin
      active_r <= active_nxt;
      count_r  <= count_nxt;
      if (op_r == OP_SET_TARGET) begin
        for (int i = 0; i < 3; i++) begin
          goal_r[i] <= tgt_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= pos_nxt[i];
      end
      kind_r    <= kind_nxt;
      act_out_r <= active_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_pos_x        = pos_r[0];
  assign out_pos_y        = pos_r[1];
  assign out_pos_z        = pos_r[2];
  assign out_write_kind   = kind_r;
  assign out_active_after = act_out_r;

`ifndef ASSERT_OFF
  a_snap_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_write_kind == KIND_SNAP) |-> !out_active_after)
    else $error("snap result left the block armed");

  a_snap_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (kind_nxt == KIND_SNAP) |=> (count_r == '0) && !active_r)
    else $error("snap did not clear the tick counter");

  a_set_arms: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (op_r == OP_SET_TARGET) |=> active_r && out_active_after)
    else $error("set-target item did not arm the block");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_write_kind == KIND_NONE) |->
      (out_pos_x == '0) && (out_pos_y == '0) && (out_pos_z == '0))
    else $error("result without a write carries a position");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> !in_stall)
    else $error("input stalled while the result register is empty");
`endif

endmodule

`default_nettype wire

// File: rtl/core/tpss_axis.sv
// One axis of the stepper: tier box checks, the step move and the arrive check.
`default_nettype none

module tpss_axis
  import tpss_pkg::*;
#(
  parameter int COORD_BITS = 26
) (
  input  wire logic signed [COORD_BITS-1:0] now,
  input  wire logic signed [COORD_BITS-1:0] goal,
  input  wire radii_t                       radii,
  input  wire step_t                        step,
  output logic             [NUM_TIERS-1:0]  tier_hit,
  output logic signed [COORD_BITS-1:0]      moved,
  output logic                              arrive_hit
);

  localparam int DW = (COORD_BITS + 2 > RADIUS_W + 2) ? COORD_BITS + 2 : RADIUS_W + 2;
  localparam int PW = COORD_BITS + 2;

  localparam logic signed [PW-1:0] COORD_MIN = {{3{1'b1}}, {(COORD_BITS-1){1'b0}}};

  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] diff_moved;
  logic signed [PW-1:0] now_e;
  logic signed [PW-1:0] goal_e;
  logic signed [PW-1:0] step_e;
  logic signed [PW-1:0] up;
  logic signed [PW-1:0] down;
  logic signed [PW-1:0] moved_e;

  function automatic logic in_radius(input logic signed [DW-1:0] d, input radius_t r);
    logic signed [DW-1:0] re;
    re = $signed({{(DW-RADIUS_W){1'b0}}, r});
    return (d < re) && (d > -re);
  endfunction

  assign diff = $signed({{(DW-COORD_BITS){goal[COORD_BITS-1]}}, goal})
              - $signed({{(DW-COORD_BITS){now[COORD_BITS-1]}}, now});

  always_comb begin
    for (int t = 0; t < NUM_TIERS; t++) begin
      tier_hit[t] = in_radius(diff, radii.tier[t]);
    end
  end

  assign now_e  = $signed({{2{now[COORD_BITS-1]}}, now});
  assign goal_e = $signed({{2{goal[COORD_BITS-1]}}, goal});
  assign step_e = $signed({{(PW-STEP_W){1'b0}}, step});
  assign up     = now_e + step_e;
  assign down   = now_e - step_e;

  // Moving up cancels a step that would pass the goal; moving down may
  // overshoot and only saturates at the coordinate minimum.
  always_comb begin
    priority if (goal_e > now_e) begin
      moved_e = (goal_e < up) ? now_e : up;
    end else if (goal_e < now_e) begin
      moved_e = (down < COORD_MIN) ? COORD_MIN : down;
    end else begin
      moved_e = now_e;
    end
  end

  assign moved = moved_e[COORD_BITS-1:0];

  assign diff_moved = $signed({{(DW-COORD_BITS){goal[COORD_BITS-1]}}, goal})
                    - $signed({{(DW-COORD_BITS){moved[COORD_BITS-1]}}, moved});
  assign arrive_hit = in_radius(diff_moved, radii.arrive);

endmodule

`default_nettype wire

// File: bench/tiered_position_slew_stepper_unit_tb.sv
// Self-checking bench for the tiered position slew stepper unit.
module tiered_position_slew_stepper_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpss_pkg::*;

  localparam int     CW             = 26;
  localparam longint CMAX           = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint CMIN           = -CMAX - 1;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     ITEMS_PER_RUN  = 230;

  typedef struct {
    logic                 op;
    logic signed [CW-1:0] tx, ty, tz;
    logic signed [CW-1:0] nx, ny, nz;
    bit                   drain_first;
  } move_cmd_t;

  typedef struct {
    logic signed [CW-1:0] px, py, pz;
    write_kind_t          kind;
    logic                 armed;
  } move_result_t;

  typedef struct {
    bit     armed;
    longint gx, gy, gz;
    int     ticks;
  } slew_state_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                 in_valid;
  logic                 in_stall;
  logic                 in_operation;
  logic signed [CW-1:0] in_target_x, in_target_y, in_target_z;
  logic signed [CW-1:0] in_now_x, in_now_y, in_now_z;

  logic                 out_valid;
  logic                 out_stall;
  logic signed [CW-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic [1:0]           out_write_kind;
  logic                 out_active_after;

  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  radius_t              cfg_data;

  // Register copies seen by the predictor.
  radius_t tier_r [NUM_TIERS];
  radius_t arrive_r;
  count_t  limit_r;

  slew_state_t  model_st;
  move_cmd_t    pending_moves [$];
  move_cmd_t    cur_cmd;
  move_result_t due_results [$];
  bit           sending = 1'b0;
  int           send_idle_pct = 30;
  int           recv_idle_pct = 65;
  int           fail_cnt = 0;
  int           quiet_cycles = 0;

  tiered_position_slew_stepper_unit #(.COORD_BITS(CW)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_target_x      (in_target_x),
    .in_target_y      (in_target_y),
    .in_target_z      (in_target_z),
    .in_now_x         (in_now_x),
    .in_now_y         (in_now_y),
    .in_now_z         (in_now_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_write_kind   (out_write_kind),
    .out_active_after (out_active_after),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit in_box(longint r, longint dx, longint dy, longint dz);
    return dx < r && dx > -r && dy < r && dy > -r && dz < r && dz > -r;
  endfunction

  // Moving up never passes the goal; moving down may, and clips at the minimum.
  function automatic longint step_axis(longint p, longint g, longint s);
    longint n;
    if (g > p) begin
      n = p + s;
      return (n > g) ? p : n;
    end else if (g < p) begin
      n = p - s;
      return (n < CMIN) ? CMIN : n;
    end
    return p;
  endfunction

  function automatic void slew_step(inout slew_state_t st, input move_cmd_t c,
                                    output move_result_t res);
    longint nx, ny, nz, s;
    int     tier;
    res.px   = '0;
    res.py   = '0;
    res.pz   = '0;
    res.kind = KIND_NONE;
    tier     = -1;
    if (c.op == OP_SET_TARGET) begin
      st.gx    = c.tx;
      st.gy    = c.ty;
      st.gz    = c.tz;
      st.armed = 1'b1;
    end else if (st.armed) begin
      // Scan from the widest tier down so that the narrowest matching tier wins.
      for (int t = NUM_TIERS - 1; t >= 0; t--) begin
        if (in_box(tier_r[t], st.gx - c.nx, st.gy - c.ny, st.gz - c.nz))
          tier = t;
      end
      if (tier >= 0) begin
        // Steps in half units run 1, 2, 4, 6, 8.
        s  = (tier == 0) ? 1 : 2 * tier;
        nx = step_axis(c.nx, st.gx, s);
        ny = step_axis(c.ny, st.gy, s);
        nz = step_axis(c.nz, st.gz, s);
        res.kind = (tier < FIRST_FREE_TIER) ? KIND_COLLIDE : KIND_FREE;
        if (in_box(arrive_r, st.gx - nx, st.gy - ny, st.gz - nz)) begin
          st.armed = 1'b0;
          st.ticks = 0;
        end
        if (st.ticks < COUNT_MAX)
          st.ticks++;
        if (st.ticks > limit_r) begin
          nx       = st.gx;
          ny       = st.gy;
          nz       = st.gz;
          res.kind = KIND_SNAP;
          st.ticks = 0;
          st.armed = 1'b0;
        end
        res.px = CW'(nx);
        res.py = CW'(ny);
        res.pz = CW'(nz);
      end
    end
    res.armed = st.armed;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    return CW'($urandom);
  endfunction

  function automatic longint clamp(longint v);
    return (v > CMAX) ? CMAX : (v < CMIN) ? CMIN : v;
  endfunction

  function automatic longint offset(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  function automatic longint pick_goal();
    case ($urandom_range(0, 9))
      0:       return CMIN + longint'($urandom_range(0, 20));
      1:       return CMAX - longint'($urandom_range(0, 20));
      2, 3:    return rand_coord();
      default: return longint'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  function automatic longint pick_span();
    longint widest;
    widest = 0;
    for (int t = 0; t < NUM_TIERS; t++)
      if (tier_r[t] > widest) widest = tier_r[t];
    if (widest > 1000) widest = 1000;
    case ($urandom_range(0, 3))
      0:       return 4;
      1:       return 24;
      2:       return widest;
      default: return 2 * widest + 8;
    endcase
  endfunction

  function automatic move_cmd_t make_set(longint x, longint y, longint z);
    move_cmd_t c;
    c.op          = OP_SET_TARGET;
    c.tx          = CW'(x);
    c.ty          = CW'(y);
    c.tz          = CW'(z);
    c.nx          = rand_coord();
    c.ny          = rand_coord();
    c.nz          = rand_coord();
    c.drain_first = 1'b0;
    return c;
  endfunction

  function automatic move_cmd_t make_tick(longint x, longint y, longint z);
    move_cmd_t c;
    c.op          = OP_TICK;
    c.tx          = rand_coord();
    c.ty          = rand_coord();
    c.tz          = rand_coord();
    c.nx          = CW'(x);
    c.ny          = CW'(y);
    c.nz          = CW'(z);
    c.drain_first = 1'b0;
    return c;
  endfunction

  // Appends an item to the driver's queue.
  function automatic void add_move(input move_cmd_t c);
    pending_moves = {pending_moves, c};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input radius_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_TIER1:   tier_r[0] = val;
      CFG_TIER2:   tier_r[1] = val;
      CFG_TIER3:   tier_r[2] = val;
      CFG_TIER4:   tier_r[3] = val;
      CFG_TIER5:   tier_r[4] = val;
      CFG_ARRIVE:  arrive_r  = val;
      CFG_TIMEOUT: limit_r   = val[COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input radius_t r1, r2, r3, r4, r5, ra, input count_t lim);
    write_reg(CFG_TIER1, r1);
    write_reg(CFG_TIER2, r2);
    write_reg(CFG_TIER3, r3);
    write_reg(CFG_TIER4, r4);
    write_reg(CFG_TIER5, r5);
    write_reg(CFG_ARRIVE, ra);
    write_reg(CFG_TIMEOUT, radius_t'(lim));
  endtask

  // Mostly trajectories that follow the block's own moves toward a goal,
  // mixed with retargets, position jumps and ticks at random places.
  task automatic plan_phase(input int n_items);
    slew_state_t  plan;
    move_result_t r;
    move_cmd_t    c;
    longint       cx, cy, cz, span;
    int           roll;
    plan = model_st;
    cx   = plan.gx;
    cy   = plan.gy;
    cz   = plan.gz;
    span = 16;
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < (plan.armed ? 3 : 70)) begin
        c    = make_set(pick_goal(), pick_goal(), pick_goal());
        span = pick_span();
        cx   = clamp(c.tx + offset(span));
        cy   = clamp(c.ty + offset(span));
        cz   = clamp(c.tz + offset(span));
      end else if (roll < (plan.armed ? 7 : 78)) begin
        c = make_tick(rand_coord(), rand_coord(), rand_coord());
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          cx = clamp(cx + offset(3));
          cy = clamp(cy + offset(3));
          cz = clamp(cz + offset(3));
        end
        c = make_tick(cx, cy, cz);
      end
      c.drain_first = ($urandom_range(0, 149) == 0);
      slew_step(plan, c, r);
      if (r.kind != KIND_NONE) begin
        cx = r.px;
        cy = r.py;
        cz = r.pz;
      end
      add_move(c);
    end
  endtask

  task automatic wait_drained();
    while (pending_moves.size() > 0 || sending || due_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [CW-1:0] want,
                             input logic signed [CW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Item driver: a presented item holds until it is taken.
  always @(negedge clk) begin
    if (rst_n && !sending) begin
      if (pending_moves.size() > 0 &&
          !(pending_moves[0].drain_first && due_results.size() > 0) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        cur_cmd = pending_moves.pop_front();
        in_operation <= cur_cmd.op;
        in_target_x  <= cur_cmd.tx;
        in_target_y  <= cur_cmd.ty;
        in_target_z  <= cur_cmd.tz;
        in_now_x     <= cur_cmd.nx;
        in_now_y     <= cur_cmd.ny;
        in_now_z     <= cur_cmd.nz;
        in_valid     <= 1'b1;
        sending = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    move_result_t r;
    if (in_valid && in_stall === 1'b0) begin
      slew_step(model_st, cur_cmd, r);
      due_results = {due_results, r};
      sending = 1'b0;
    end
  end

  always @(negedge clk)
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  always @(posedge clk) begin
    move_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_results.size() == 0) begin
        $error("result item with nothing pending: x=%0d y=%0d z=%0d kind=%0d",
               out_pos_x, out_pos_y, out_pos_z, out_write_kind);
        fail_cnt++;
      end else begin
        want = due_results.pop_front();
        check_field("out_pos_x", want.px, out_pos_x);
        check_field("out_pos_y", want.py, out_pos_y);
        check_field("out_pos_z", want.pz, out_pos_z);
        check_field("out_write_kind", want.kind, out_write_kind);
        check_field("out_active_after", want.armed, out_active_after);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_SET_TARGET;
    in_target_x  = '0;
    in_target_y  = '0;
    in_target_z  = '0;
    in_now_x     = '0;
    in_now_y     = '0;
    in_now_z     = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_TIER1;
    cfg_data     = '0;
    tier_r       = '{RST_TIER1, RST_TIER2, RST_TIER3, RST_TIER4, RST_TIER5};
    arrive_r     = RST_ARRIVE;
    limit_r      = RST_TIMEOUT;
    model_st     = '{armed: 1'b0, gx: 0, gy: 0, gz: 0, ticks: 0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items on the reset register values.
    add_move(make_tick(CMIN, CMAX, 0));
    add_move(make_set(CMAX, CMAX, CMIN));
    add_move(make_tick(CMIN, CMIN, CMAX));
    add_move(make_tick(CMAX - 5, CMAX - 1, CMIN + 3));
    add_move(make_set(CMIN, 0, 100));
    // x clips at the minimum, y is held back short of the goal.
    add_move(make_tick(CMIN + 3, -2, -200));
    // y overshoots downward.
    add_move(make_tick(CMIN, 3, -196));
    add_move(make_tick(CMIN, 0, -400));
    add_move(make_tick(CMIN, 0, 800));
    add_move(make_tick(CMIN, 0, -700));
    add_move(make_tick(CMIN, 0, 240));
    add_move(make_tick(CMIN, 0, -39));
    add_move(make_tick(CMIN, 0, -1));
    add_move(make_tick(CMIN, 0, 0));
    add_move(make_tick(5, 5, 5));
    add_move(make_set(1000, 1000, 1000));
    add_move(make_tick(300, 300, 300));
    // Retarget while still armed.
    add_move(make_set(5, -5, 5));
    add_move(make_tick(0, 0, 0));
    add_move(make_tick(rand_coord(), rand_coord(), rand_coord()));
    wait_drained();

    set_regs(10, 30, 80, 160, 300, 20, 3000);
    plan_phase(ITEMS_PER_RUN);
    wait_drained();
    set_regs(3, 6, 12, 24, 48, 2, 40);
    plan_phase(ITEMS_PER_RUN);
    wait_drained();

    send_idle_pct = 65;
    recv_idle_pct = 30;
    set_regs(1, '1, '1, '1, '1, '1, 0);
    plan_phase(ITEMS_PER_RUN);
    wait_drained();
    set_regs(1, 1, 1, 1, '1, 1, 4094);
    plan_phase(ITEMS_PER_RUN);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(radius_t'($urandom_range(1, 2000)), radius_t'($urandom_range(1, 2000)),
             radius_t'($urandom_range(1, 2000)), radius_t'($urandom_range(1, 2000)),
             radius_t'($urandom_range(1, 2000)), radius_t'($urandom_range(1, 300)),
             count_t'($urandom_range(1, 60)));
    plan_phase(ITEMS_PER_RUN);
    wait_drained();
    set_regs(RST_TIER1, RST_TIER2, RST_TIER3, RST_TIER4, RST_TIER5, RST_ARRIVE,
             RST_TIMEOUT);
    plan_phase(ITEMS_PER_RUN);
    wait_drained();

    repeat (8) @(posedge clk);
    if (fail_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
